// ===== hw/rtl/srl_pkg.sv =====
// Shared types, codes and decode helpers for the S-record word loader.
package srl_pkg;

    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;

    localparam logic [19:0] MAX_WORDS_RESET = 20'hFFFFF;
    localparam logic [3:0]  TYPE_WORDS      = 4'd3;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_S     = 3'd1,
        ERR_BAD_TYPE = 3'd2,
        ERR_BAD_HEX  = 3'd3,
        ERR_BAD_LEN  = 3'd4,
        ERR_CHECKSUM = 3'd5,
        ERR_LIMIT    = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_CHECK,
        SQ_READ,
        SQ_WORD,
        SQ_STATUS,
        SQ_ERROR
    } seq_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic       is_s;
        logic       is_digit;
        logic [3:0] digit;
        logic       type_ok;
        logic       is_hex;
        logic [3:0] hex;
    } char_class_t;

    typedef struct packed {
        logic [19:0] result;
        logic        borrow;
    } alu_out_t;

    function automatic logic type_valid(input logic [3:0] t);
        case (t)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: type_valid = 1'b1;
            default: type_valid = 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] addr_len(input logic [3:0] t);
        case (t)
            4'd0, 4'd1, 4'd9: addr_len = 3'd2;
            4'd2, 4'd8:       addr_len = 3'd3;
            4'd3, 4'd7:       addr_len = 3'd4;
            default:          addr_len = 3'd0;
        endcase
    endfunction

    // Smallest legal byte count: address bytes plus the checksum byte.
    function automatic logic [2:0] count_min(input logic [3:0] t);
        case (t)
            4'd0, 4'd1, 4'd9: count_min = 3'd3;
            4'd2, 4'd8:       count_min = 3'd4;
            4'd3, 4'd7:       count_min = 3'd5;
            default:          count_min = 3'd1;
        endcase
    endfunction

endpackage

// ===== hw/rtl/srec_record_word_loader.sv =====
// S-record character parser that delivers checked type 3 data as 32-bit words.
//
//  channel | signals                        | content
//  --------+--------------------------------+-----------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser | one record character per request
//  m       | m_tvalid m_tready m_tdata m_tuser m_tlast | words, record status, errors
//  cfg     | cfg_valid cfg_ready cfg_data   | max_words register write
//
// A character is accepted, then executed; the byte count and checksum
// bytes also pass a check step in the shared add/subtract unit.
// After a good checksum each buffered word is read from RAM and emitted, then one
// status request follows (an error at the max_words limit); errors give one request.
// Reset clears all control state; the word buffer needs no clearing.
// The output register lets the block run on while one request waits on m_tready.
module srec_record_word_loader
    import srl_pkg::*;
#(
    parameter int WORD_BUFFER_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [1:0]  s_tuser,   // [0] line_start, [1] new_load
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] word_value, [51:32] word_index,
                                   // [55:52] record_kind, [87:56] record_address,
                                   // [90:88] error_code, [95:91] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    localparam int AW        = WORD_BUFFER_DEPTH > 1 ? $clog2(WORD_BUFFER_DEPTH) : 1;
    localparam int CW        = $clog2(WORD_BUFFER_DEPTH + 1);
    localparam int MAX_BYTES = 4 * WORD_BUFFER_DEPTH;

    seq_t         state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [7:0]   ch_reg;
    logic         ls_reg;
    logic         hi_seen_reg, hi_seen_next;
    logic [3:0]   nib_reg, nib_next;
    logic [7:0]   byte_reg, byte_next;
    logic [3:0]   rtype_reg, rtype_next;
    logic [2:0]   addr_left_reg, addr_left_next;
    logic [31:0]  addr_reg, addr_next;
    logic [7:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]   sum_reg, sum_next;
    logic [1:0]   byte_pos_reg, byte_pos_next;
    logic [23:0]  word_acc_reg, word_acc_next;
    logic [CW-1:0] nwords_reg, nwords_next;
    logic [CW-1:0] drain_idx_reg, drain_idx_next;
    logic [19:0]  loaded_reg, loaded_next;
    logic         halted_reg, halted_next;
    logic         limit_hit_reg, limit_hit_next;
    err_t         err_reg, err_next;
    logic [19:0]  max_words_reg;

    logic         m_tvalid_reg;
    logic [95:0]  m_tdata_reg;
    logic [1:0]   m_tuser_reg;
    logic         m_tlast_reg;

    char_class_t  cls;
    alu_op_t      alu_op;
    logic [19:0]  alu_a, alu_b;
    alu_out_t     alu_res;

    logic         ram_wr_en, ram_rd_en;
    logic [31:0]  ram_rd_data;

    logic         in_accept, halted_eff, out_free;
    logic [7:0]   byte_now;
    logic [2:0]   al;
    logic [7:0]   bl;
    logic         ex_err, ex_check, ck_err, ck_drain;
    err_t         ex_code, ck_code;

    logic         out_load;
    kind_t        out_kind;
    logic [31:0]  out_word;
    err_t         out_err;
    logic         out_last;

    srl_decode u_decode (
        .ch  (ch_reg),
        .cls (cls)
    );

    srl_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    srl_ram #(
        .WIDTH (32),
        .DEPTH (WORD_BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (nwords_reg[AW-1:0]),
        .wr_data ({word_acc_reg, byte_now}),
        .rd_en   (ram_rd_en),
        .rd_addr (drain_idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign halted_eff = halted_reg && !s_tuser[1];
    assign out_free = !m_tvalid_reg || m_tready;
    assign byte_now = {nib_reg, cls.hex};
    assign al = addr_len(rtype_reg);
    assign bl = alu_res.result[7:0];

    always_comb
    begin
        ex_err   = 1'b0;
        ex_code  = ERR_NONE;
        ex_check = 1'b0;
        if (ls_reg)
        begin
            if (phase_reg != PH_WAIT)
            begin
                ex_err  = 1'b1;
                ex_code = ERR_BAD_LEN;
            end
            else if (!cls.is_s)
            begin
                ex_err  = 1'b1;
                ex_code = ERR_NO_S;
            end
        end
        else if (phase_reg == PH_TYPE)
        begin
            if (!cls.type_ok)
            begin
                ex_err  = 1'b1;
                ex_code = ERR_BAD_TYPE;
            end
        end
        else if (phase_reg != PH_WAIT)
        begin
            if (!cls.is_hex)
            begin
                ex_err  = 1'b1;
                ex_code = ERR_BAD_HEX;
            end
            else if (hi_seen_reg && (phase_reg == PH_COUNT || phase_reg == PH_SUM))
            begin
                ex_check = 1'b1;
            end
        end

        ck_err   = 1'b0;
        ck_code  = ERR_NONE;
        ck_drain = 1'b0;
        if (phase_reg == PH_COUNT)
        begin
            if (alu_res.borrow || ((rtype_reg == TYPE_WORDS) &&
                ((bl[1:0] != 2'd0) || ({1'b0, bl} > 9'(MAX_BYTES)))))
            begin
                ck_err  = 1'b1;
                ck_code = ERR_BAD_LEN;
            end
        end
        else if (alu_res.result != 20'd0)
        begin
            ck_err  = 1'b1;
            ck_code = ERR_CHECKSUM;
        end
        else
        begin
            ck_drain = (rtype_reg == TYPE_WORDS) && (nwords_reg != '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (in_accept && !halted_eff)
                begin
                    state_next = SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                if (ex_err)
                begin
                    state_next = SQ_ERROR;
                end
                else if (ex_check)
                begin
                    state_next = SQ_CHECK;
                end
                else
                begin
                    state_next = SQ_IDLE;
                end
            end
            SQ_CHECK:
            begin
                if (ck_err)
                begin
                    state_next = SQ_ERROR;
                end
                else if (phase_reg == PH_COUNT)
                begin
                    state_next = SQ_IDLE;
                end
                else if (ck_drain)
                begin
                    state_next = SQ_READ;
                end
                else
                begin
                    state_next = SQ_STATUS;
                end
            end
            SQ_READ:
            begin
                state_next = (drain_idx_reg == nwords_reg) ? SQ_STATUS : SQ_WORD;
            end
            SQ_WORD:
            begin
                if (limit_hit_reg)
                begin
                    state_next = SQ_ERROR;
                end
                else if (out_free)
                begin
                    state_next = SQ_READ;
                end
            end
            SQ_STATUS, SQ_ERROR:
            begin
                if (out_free)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == SQ_IDLE);
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        alu_op    = ALU_ADD;
        alu_a     = {12'd0, sum_reg};
        alu_b     = {12'd0, byte_now};
        out_load  = 1'b0;
        out_kind  = KIND_WORD;
        out_word  = ram_rd_data;
        out_err   = ERR_NONE;
        out_last  = 1'b0;
        case (state_reg)
            SQ_EXEC:
            begin
                ram_wr_en = !ls_reg && (phase_reg == PH_DATA) && cls.is_hex &&
                            hi_seen_reg && (rtype_reg == TYPE_WORDS) &&
                            (byte_pos_reg == 2'd3);
            end
            SQ_CHECK:
            begin
                alu_op = ALU_SUB;
                alu_a  = {12'd0, byte_reg};
                alu_b  = (phase_reg == PH_COUNT) ? {17'd0, count_min(rtype_reg)}
                                                 : {12'd0, ~sum_reg};
            end
            SQ_READ:
            begin
                ram_rd_en = (drain_idx_reg != nwords_reg);
                alu_op    = ALU_SUB;
                alu_a     = loaded_reg;
                alu_b     = max_words_reg;
            end
            SQ_WORD:
            begin
                alu_a    = loaded_reg;
                alu_b    = 20'd1;
                out_load = !limit_hit_reg && out_free;
            end
            SQ_STATUS:
            begin
                out_load = out_free;
                out_kind = KIND_RECORD;
                out_word = '0;
                out_last = 1'b1;
            end
            SQ_ERROR:
            begin
                out_load = out_free;
                out_kind = KIND_ERROR;
                out_word = '0;
                out_err  = err_reg;
                out_last = 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        hi_seen_next    = hi_seen_reg;
        nib_next        = nib_reg;
        byte_next       = byte_reg;
        rtype_next      = rtype_reg;
        addr_left_next  = addr_left_reg;
        addr_next       = addr_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        byte_pos_next   = byte_pos_reg;
        word_acc_next   = word_acc_reg;
        nwords_next     = nwords_reg;
        drain_idx_next  = drain_idx_reg;
        loaded_next     = loaded_reg;
        halted_next     = halted_reg;
        limit_hit_next  = limit_hit_reg;
        err_next        = err_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (in_accept && s_tuser[1])
                begin
                    loaded_next = '0;
                    halted_next = 1'b0;
                end
            end
            SQ_EXEC:
            begin
                if (ex_err)
                begin
                    err_next    = ex_code;
                    halted_next = 1'b1;
                    phase_next  = PH_WAIT;
                    if (phase_reg == PH_TYPE && !ls_reg && cls.is_digit)
                    begin
                        rtype_next = cls.digit;
                    end
                end
                else if (ls_reg)
                begin
                    phase_next      = PH_TYPE;
                    hi_seen_next    = 1'b0;
                    nib_next        = '0;
                    rtype_next      = '0;
                    addr_next       = '0;
                    sum_next        = '0;
                    byte_pos_next   = '0;
                    nwords_next     = '0;
                    bytes_left_next = '0;
                    addr_left_next  = '0;
                end
                else if (phase_reg == PH_TYPE)
                begin
                    rtype_next = cls.digit;
                    phase_next = PH_COUNT;
                end
                else if (phase_reg != PH_WAIT)
                begin
                    if (!hi_seen_reg)
                    begin
                        nib_next     = cls.hex;
                        hi_seen_next = 1'b1;
                    end
                    else
                    begin
                        hi_seen_next = 1'b0;
                        byte_next    = byte_now;
                        if (phase_reg != PH_SUM)
                        begin
                            sum_next = alu_res.result[7:0];
                        end
                        if (phase_reg == PH_ADDR)
                        begin
                            addr_next      = {addr_reg[23:0], byte_now};
                            addr_left_next = addr_left_reg - 3'd1;
                            if (addr_left_reg == 3'd1)
                            begin
                                phase_next = (bytes_left_reg != 8'd0) ? PH_DATA : PH_SUM;
                            end
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            if (rtype_reg == TYPE_WORDS)
                            begin
                                word_acc_next = {word_acc_reg[15:0], byte_now};
                                byte_pos_next = byte_pos_reg + 2'd1;
                                if (byte_pos_reg == 2'd3)
                                begin
                                    nwords_next = nwords_reg + CW'(1);
                                end
                            end
                            bytes_left_next = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1)
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                    end
                end
            end
            SQ_CHECK:
            begin
                if (ck_err)
                begin
                    err_next    = ck_code;
                    halted_next = 1'b1;
                    phase_next  = PH_WAIT;
                end
                else if (phase_reg == PH_COUNT)
                begin
                    bytes_left_next = bl;
                    addr_left_next  = al;
                    if (al != 3'd0)
                    begin
                        phase_next = PH_ADDR;
                    end
                    else
                    begin
                        phase_next = (bl != 8'd0) ? PH_DATA : PH_SUM;
                    end
                end
                else
                begin
                    phase_next     = PH_WAIT;
                    drain_idx_next = '0;
                end
            end
            SQ_READ:
            begin
                limit_hit_next = !alu_res.borrow;
            end
            SQ_WORD:
            begin
                if (limit_hit_reg)
                begin
                    err_next    = ERR_LIMIT;
                    halted_next = 1'b1;
                    phase_next  = PH_WAIT;
                end
                else if (out_free)
                begin
                    loaded_next    = alu_res.result;
                    drain_idx_next = drain_idx_reg + CW'(1);
                end
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_IDLE;
            phase_reg      <= PH_WAIT;
            hi_seen_reg    <= 1'b0;
            nib_reg        <= '0;
            rtype_reg      <= '0;
            addr_left_reg  <= '0;
            addr_reg       <= '0;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
            byte_pos_reg   <= '0;
            nwords_reg     <= '0;
            drain_idx_reg  <= '0;
            loaded_reg     <= '0;
            halted_reg     <= 1'b0;
            limit_hit_reg  <= 1'b0;
            err_reg        <= ERR_NONE;
            max_words_reg  <= MAX_WORDS_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hi_seen_reg    <= hi_seen_next;
            nib_reg        <= nib_next;
            rtype_reg      <= rtype_next;
            addr_left_reg  <= addr_left_next;
            addr_reg       <= addr_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            byte_pos_reg   <= byte_pos_next;
            nwords_reg     <= nwords_next;
            drain_idx_reg  <= drain_idx_next;
            loaded_reg     <= loaded_next;
            halted_reg     <= halted_next;
            limit_hit_reg  <= limit_hit_next;
            err_reg        <= err_next;
            if (cfg_valid && cfg_ready)
            begin
                max_words_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg <= s_tdata;
            ls_reg <= s_tuser[0];
        end
        byte_reg     <= byte_next;
        word_acc_reg <= word_acc_next;
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, out_err, addr_reg, rtype_reg, loaded_reg, out_word};
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_nwords_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nwords_reg <= CW'(WORD_BUFFER_DEPTH))
        else $error("word buffer count exceeds its depth");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_READ || state_reg == SQ_WORD) |-> drain_idx_reg <= nwords_reg)
        else $error("drain index passed the buffered word count");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SQ_ERROR |-> halted_reg && phase_reg == PH_WAIT)
        else $error("error request without halt");

    a_only_words_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !out_last |-> out_kind == KIND_WORD)
        else $error("non-word request without last");

endmodule

// ===== hw/rtl/srl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/srl_decode.sv =====
// Character classifier: record mark, type digit and hex digit decode.
module srl_decode
    import srl_pkg::*;
(
    input  logic [7:0]  ch,
    output char_class_t cls
);

    logic       digit;
    logic       upper;
    logic       lower;
    logic [3:0] dval;

    always_comb
    begin
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        upper = (ch >= CH_UA) && (ch <= CH_UF);
        lower = (ch >= CH_LA) && (ch <= CH_LF);
        dval  = 4'(ch - CH_ZERO);

        cls.is_s     = (ch == CH_S);
        cls.is_digit = digit;
        cls.digit    = dval;
        cls.type_ok  = digit && type_valid(dval);
        cls.is_hex   = digit || upper || lower;
        cls.hex      = digit ? dval : 4'(ch[3:0] + 4'd9);
    end

endmodule

// ===== hw/rtl/srl_alu.sv =====
// Shared 20-bit add/subtract unit used for sums, length checks and word limits.
module srl_alu
    import srl_pkg::*;
(
    input  alu_op_t     op,
    input  logic [19:0] a,
    input  logic [19:0] b,
    output alu_out_t    res
);

    logic [20:0] wide;

    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = '0;
        endcase
        res.result = wide[19:0];
        res.borrow = (op == ALU_SUB) && wide[20];
    end

endmodule

// ===== verif/tb_srec_record_word_loader.sv =====
// Self-checking testbench for the S-record word loader: directed rows, random records, limits.
module tb_srec_record_word_loader;
    import srl_pkg::*;

    localparam int     BUFFER_WORDS   = 64;
    localparam int     HALF_PERIOD    = 6;
    localparam int     MAX_GAP        = 19;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     HOLD_CYCLES    = 400;
    localparam longint TIMEOUT_CYCLES = 600000;

    typedef struct {
        kind_t       kind;
        logic [31:0] value;
        logic [19:0] index;
        logic [3:0]  rkind;
        logic [31:0] addr;
        err_t        err;
        logic        last;
    } loader_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [19:0] cfg_data;

    srec_record_word_loader #(
        .WORD_BUFFER_DEPTH(BUFFER_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Predicted parser state.
    phase_t      pr_phase;
    bit          pr_high_seen;
    logic [3:0]  pr_high_nib;
    logic [3:0]  pr_type;
    logic [2:0]  pr_addr_left;
    logic [31:0] pr_addr;
    logic [7:0]  pr_left;
    logic [7:0]  pr_sum;
    logic [31:0] pr_words [BUFFER_WORDS];
    logic [7:0]  pr_stored;
    logic [19:0] pr_loaded;
    bit          pr_halted;
    logic [19:0] pr_limit;

    loader_result_t pending_results[$];
    logic [7:0]     line_q[$];

    string row_text[$];
    bit    row_fresh[$];
    bit    row_typed[$];
    kind_t row_kind[$];
    err_t  row_err[$];

    bit    typed_pending = 1'b0;
    kind_t typed_kind;
    err_t  typed_err;
    bit    hold_request = 1'b0;
    bit    sender_steady = 1'b0;

    int sent_chars = 0;
    int parsed_chars = 0;
    int predicted_total = 0;
    int limit_writes = 0;
    int words_seen = 0;
    int records_seen = 0;
    int errors_seen = 0;
    int mismatches = 0;

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic int addr_bytes_for(input int rtype);
        case (rtype)
            0, 1, 9: return 2;
            2, 8:    return 3;
            3, 7:    return 4;
            5, 6:    return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return CH_ZERO + nib;
        return (lower ? CH_LA : CH_UA) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void push_result(input kind_t kind, input logic [31:0] value,
                                        input err_t err, input logic last);
        loader_result_t r;
        r.kind  = kind;
        r.value = value;
        r.index = pr_loaded;
        r.rkind = pr_type;
        r.addr  = pr_addr;
        r.err   = err;
        r.last  = last;
        if (last && typed_pending)
        begin
            r.kind = typed_kind;
            r.err = typed_err;
            typed_pending = 1'b0;
        end
        pending_results.push_back(r);
        predicted_total++;
    endfunction

    function automatic void reject(input err_t code);
        push_result(KIND_ERROR, 32'd0, code, 1'b1);
        pr_halted = 1'b1;
        pr_phase = PH_WAIT;
    endfunction

    function automatic void close_record();
        int nw;
        nw = pr_stored >> 2;
        if (pr_type == TYPE_WORDS)
        begin
            for (int i = 0; i < nw && i < BUFFER_WORDS; i++)
            begin
                if (pr_loaded >= pr_limit)
                begin
                    reject(ERR_LIMIT);
                    return;
                end
                push_result(KIND_WORD, pr_words[i], ERR_NONE, 1'b0);
                pr_loaded++;
            end
        end
        push_result(KIND_RECORD, 32'd0, ERR_NONE, 1'b1);
        pr_phase = PH_WAIT;
    endfunction

    function automatic void reset_predictor();
        pr_phase = PH_WAIT;
        pr_high_seen = 1'b0;
        pr_high_nib = '0;
        pr_type = '0;
        pr_addr_left = '0;
        pr_addr = '0;
        pr_left = '0;
        pr_sum = '0;
        foreach (pr_words[i]) pr_words[i] = '0;
        pr_stored = '0;
        pr_loaded = '0;
        pr_halted = 1'b0;
        pr_limit = MAX_WORDS_RESET;
    endfunction

    function automatic void parse_char(input logic [7:0] ch, input bit ls, input bit nl);
        int         nib;
        int         alen;
        int         w;
        logic [7:0] b;
        if (nl)
        begin
            pr_loaded = '0;
            pr_halted = 1'b0;
        end
        if (pr_halted) return;
        if (ls)
        begin
            parsed_chars++;
            if (pr_phase != PH_WAIT)
            begin
                reject(ERR_BAD_LEN);
                return;
            end
            if (ch != CH_S)
            begin
                reject(ERR_NO_S);
                return;
            end
            pr_phase = PH_TYPE;
            pr_high_seen = 1'b0;
            pr_high_nib = '0;
            pr_type = '0;
            pr_addr = '0;
            pr_sum = '0;
            pr_stored = '0;
            pr_left = '0;
            pr_addr_left = '0;
            return;
        end
        if (pr_phase == PH_WAIT) return;
        parsed_chars++;
        if (pr_phase == PH_TYPE)
        begin
            if (ch >= CH_ZERO && ch <= CH_NINE) pr_type = ch - CH_ZERO;
            if (ch < CH_ZERO || ch > CH_NINE || addr_bytes_for(pr_type) < 0)
            begin
                reject(ERR_BAD_TYPE);
                return;
            end
            pr_phase = PH_COUNT;
            return;
        end
        nib = hex_digit(ch);
        if (nib < 0)
        begin
            reject(ERR_BAD_HEX);
            return;
        end
        if (!pr_high_seen)
        begin
            pr_high_nib = nib[3:0];
            pr_high_seen = 1'b1;
            return;
        end
        pr_high_seen = 1'b0;
        b = {pr_high_nib, nib[3:0]};
        case (pr_phase)
            PH_COUNT:
            begin
                alen = addr_bytes_for(pr_type);
                pr_sum += b;
                if (b < alen + 1)
                begin
                    reject(ERR_BAD_LEN);
                    return;
                end
                pr_left = b - alen - 1;
                if (pr_type == TYPE_WORDS && pr_left[1:0] != 2'd0)
                begin
                    reject(ERR_BAD_LEN);
                    return;
                end
                pr_addr_left = alen[2:0];
                pr_phase = alen > 0 ? PH_ADDR : (pr_left > 0 ? PH_DATA : PH_SUM);
            end
            PH_ADDR:
            begin
                pr_sum += b;
                pr_addr = {pr_addr[23:0], b};
                pr_addr_left--;
                if (pr_addr_left == 3'd0) pr_phase = pr_left > 0 ? PH_DATA : PH_SUM;
            end
            PH_DATA:
            begin
                pr_sum += b;
                if (pr_type == TYPE_WORDS)
                begin
                    w = (pr_stored >> 2) % BUFFER_WORDS;
                    if (pr_stored[1:0] == 2'd0) pr_words[w] = {24'd0, b};
                    else pr_words[w] = {pr_words[w][23:0], b};
                    pr_stored++;
                end
                pr_left--;
                if (pr_left == 8'd0) pr_phase = PH_SUM;
            end
            PH_SUM:
            begin
                if (b != ~pr_sum) reject(ERR_CHECKSUM);
                else close_record();
            end
            default: pr_phase = PH_WAIT;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        loader_result_t e;
        case (m_tuser)
            KIND_WORD:   words_seen++;
            KIND_RECORD: records_seen++;
            default:     errors_seen++;
        endcase
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: kind %0h, data %0h", m_tuser, m_tdata);
            mismatches++;
        end
        else
        begin
            e = pending_results.pop_front();
            check_field("kind", e.kind, m_tuser);
            check_field("word_value", e.value, m_tdata[31:0]);
            check_field("word_index", e.index, m_tdata[51:32]);
            check_field("record_kind", e.rkind, m_tdata[55:52]);
            check_field("record_address", e.addr, m_tdata[87:56]);
            check_field("error_code", e.err, m_tdata[90:88]);
            check_field("last", e.last, m_tlast);
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input bit ls, input bit nl);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tuser <= {nl, ls};
        do @(posedge clk); while (!s_tready);
        parse_char(ch, ls, nl);
        sent_chars++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [19:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pr_limit = value;
        limit_writes++;
    endtask

    task automatic build_record(input int rtype, input int ndata, input bit lower);
        logic [7:0] raw[$];
        logic [7:0] total;
        logic [7:0] count_byte;
        logic [7:0] type_char;
        int         alen;
        alen = addr_bytes_for(rtype);
        count_byte = ndata + alen + 1;
        raw.push_back(count_byte);
        repeat (alen) raw.push_back(random_byte());
        repeat (ndata) raw.push_back(random_byte());
        total = '0;
        foreach (raw[i]) total += raw[i];
        raw.push_back(~total);
        line_q.delete();
        type_char = CH_ZERO + rtype;
        line_q.push_back(CH_S);
        line_q.push_back(type_char);
        foreach (raw[i])
        begin
            line_q.push_back(hex_char(raw[i][7:4], lower));
            line_q.push_back(hex_char(raw[i][3:0], lower));
        end
    endtask

    task automatic corrupt_line();
        int pos;
        int keep;
        case ($urandom_range(0, 5))
            0: line_q[line_q.size() - 1] = hex_char($urandom_range(0, 15), 1'b0);
            1:
            begin
                line_q[2] = hex_char($urandom_range(0, 15), 1'b0);
                line_q[3] = hex_char($urandom_range(0, 15), 1'b0);
            end
            2:
            begin
                pos = $urandom_range(1, line_q.size() - 1);
                line_q[pos] = $urandom_range(0, 255);
            end
            3:
            begin
                keep = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > keep) line_q.delete(line_q.size() - 1);
            end
            4: line_q[0] = $urandom_range(0, 255);
            default: line_q[1] = $urandom_range(0, 255);
        endcase
    endtask

    task automatic random_record();
        int rtype;
        int pick;
        int ndata;
        if ($urandom_range(0, 9) < 6)
        begin
            rtype = TYPE_WORDS;
            if ($urandom_range(0, 11) == 0) ndata = 4 * $urandom_range(5, 16);
            else ndata = 4 * $urandom_range(0, 4);
        end
        else
        begin
            pick = $urandom_range(0, 7);
            rtype = pick < 3 ? pick : pick + 2;
            ndata = $urandom_range(0, 6);
        end
        build_record(rtype, ndata, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0) corrupt_line();
    endtask

    task automatic send_line(input bit fresh);
        if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
        foreach (line_q[i])
            send_char(line_q[i], i == 0, (i == 0 && fresh) || $urandom_range(0, 99) == 0);
        repeat ($urandom_range(0, 2))
            send_char($urandom_range(0, 255), 1'b0, $urandom_range(0, 19) == 0);
    endtask

    task automatic run_random(input int char_goal, input int result_goal);
        int chars_at_start;
        int results_at_start;
        chars_at_start = parsed_chars;
        results_at_start = predicted_total;
        while (parsed_chars - chars_at_start < char_goal ||
               predicted_total - results_at_start < result_goal)
        begin
            random_record();
            send_line(pr_halted ? $urandom_range(0, 9) < 7 : $urandom_range(0, 19) == 0);
            if ($urandom_range(0, 24) == 0) drain();
        end
    endtask

    task automatic add_row(input string text, input bit fresh, input bit typed,
                           input kind_t kind, input err_t err);
        row_text.push_back(text);
        row_fresh.push_back(fresh);
        row_typed.push_back(typed);
        row_kind.push_back(kind);
        row_err.push_back(err);
    endtask

    task automatic run_table();
        add_row("S1030000FC", 1'b0, 1'b1, KIND_RECORD, ERR_NONE);
        add_row("S5030102F9", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S30900001000A1B2C3D4FC", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row({"S3090000", "ffffffffffff", "fc"}, 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S30500000000FA", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S205012345672A", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S00600004844521B", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S70500000000FA", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S804000000FB", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S9030000FC", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S6030000FC", 1'b0, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("X1030000FC", 1'b0, 1'b1, KIND_ERROR, ERR_NO_S);
        add_row("S4030000FC", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_TYPE);
        add_row("SA03", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_TYPE);
        add_row("S1G3", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_HEX);
        add_row("S1\377", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_HEX);
        add_row("S10200FD", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_LEN);
        add_row("S3060000000000F9", 1'b1, 1'b1, KIND_ERROR, ERR_BAD_LEN);
        add_row("S10300", 1'b1, 1'b0, KIND_RECORD, ERR_NONE);
        add_row("S1030000FC", 1'b0, 1'b1, KIND_ERROR, ERR_BAD_LEN);
        add_row("S1030000FD", 1'b1, 1'b1, KIND_ERROR, ERR_CHECKSUM);
        add_row("S1030000FC\015\n", 1'b1, 1'b1, KIND_RECORD, ERR_NONE);
        for (int r = 0; r < row_text.size(); r++)
        begin
            typed_pending = row_typed[r];
            typed_kind = row_kind[r];
            typed_err = row_err[r];
            for (int i = 0; i < row_text[r].len(); i++)
                send_char(row_text[r][i], i == 0, i == 0 && row_fresh[r]);
        end
        typed_pending = 1'b0;
    endtask

    initial
    begin
        int steady;
        int stall;
        steady = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 31) == 0) steady = !steady;
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result();
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_table();

        write_limit($urandom_range(1, 12));
        run_random(100, 30);

        write_limit(20'd0);
        run_random(100, 30);

        // The receiver holds off while a full-size record and more lines keep coming.
        write_limit(20'hFFFFF);
        hold_request = 1'b1;
        build_record(TYPE_WORDS, 4 * 62, 1'b0);
        send_line(1'b1);
        repeat (4)
        begin
            random_record();
            send_line(pr_halted);
        end
        run_random(100, 30);

        drain();
        $display("Sent %0d characters (%0d parsed) across %0d max_words settings.",
                 sent_chars, parsed_chars, limit_writes + 1);
        $display("Checked %0d data words, %0d record statuses and %0d errors.",
                 words_seen, records_seen, errors_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $error("timeout with %0d results still expected", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
